// ===== src/sse_pkg.sv =====
// Shared types and constants for the sorted set engine.
package sse_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] OP_MEMBER = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef struct packed {
        logic [1:0] op;
        t_key       value;
    } t_req;

    typedef struct packed {
        logic success;
        logic full_res;
    } t_res;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_key              wdata;
    } t_mem_req;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cmp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } t_state;

endpackage

// ===== src/sse_store.sv =====
// Key store: one write port and one registered read port.
module sse_store (
    input  logic              i_clk,
    input  sse_pkg::t_mem_req i_req,
    output sse_pkg::t_key     o_rdata
);

    sse_pkg::t_key r_mem [sse_pkg::CAPACITY];
    sse_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sse_cmp.sv =====
// Shared signed comparator between a stored key and the requested key.
module sse_cmp (
    input  sse_pkg::t_key i_data,
    input  sse_pkg::t_key i_key,
    output sse_pkg::t_cmp o_cmp
);

    assign o_cmp.lt = (i_data < i_key);
    assign o_cmp.eq = (i_data == i_key);

endmodule

// ===== src/sse_seq.sv =====
// Sequencer: linear search, then shifting of entries for insert and delete.
module sse_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sse_pkg::t_req     i_req,
    output logic              busy,
    output logic              o_valid,
    output sse_pkg::t_res     o_res,
    output sse_pkg::t_mem_req o_mem,
    input  sse_pkg::t_key     i_rdata,
    input  sse_pkg::t_cmp     i_cmp,
    output sse_pkg::t_key     o_key
);

    sse_pkg::t_state            r_state, n_state;
    logic [1:0]                 r_op, n_op;
    sse_pkg::t_key              r_key, n_key;
    logic [sse_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [sse_pkg::CNT_W-1:0]  r_pos, n_pos;
    logic [sse_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_ok, n_ok;
    logic                       r_full, n_full;

    logic [sse_pkg::CNT_W-1:0]  w_prev, w_next;
    logic                       w_held;

    assign w_prev = r_idx - sse_pkg::CNT_W'(1);
    assign w_next = r_idx + sse_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_ok   <= n_ok;
        r_full <= n_full;
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_key   = r_key;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_ok    = r_ok;
        n_full  = r_full;
        w_held  = 1'b0;
        o_mem   = '0;

        unique case (r_state) inside
            sse_pkg::S_IDLE: begin
                if (start) begin
                    n_op    = i_req.op;
                    n_key   = i_req.value;
                    n_idx   = '0;
                    n_ok    = 1'b0;
                    n_full  = 1'b0;
                    n_state = sse_pkg::S_SRCH_RD;
                end
            end
            sse_pkg::S_SRCH_RD, sse_pkg::S_SRCH_CMP: begin
                if (r_state == sse_pkg::S_SRCH_RD && r_idx != r_cnt) begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx[sse_pkg::ADDR_W-1:0];
                    n_state     = sse_pkg::S_SRCH_CMP;
                end else if (r_state == sse_pkg::S_SRCH_CMP && i_cmp.lt) begin
                    n_idx   = w_next;
                    n_state = sse_pkg::S_SRCH_RD;
                end else begin
                    // Search ended at r_idx: end of list or first key not below.
                    w_held  = (r_state == sse_pkg::S_SRCH_CMP) && i_cmp.eq;
                    n_pos   = r_idx;
                    n_state = sse_pkg::S_DONE;
                    unique case (r_op)
                        sse_pkg::OP_MEMBER: begin
                            n_ok = w_held;
                        end
                        sse_pkg::OP_INSERT: begin
                            if (!w_held) begin
                                if (r_cnt == sse_pkg::CAP_CNT) begin
                                    n_full = 1'b1;
                                end else begin
                                    n_idx   = r_cnt;
                                    n_state = sse_pkg::S_INS_RD;
                                end
                            end
                        end
                        sse_pkg::OP_DELETE: begin
                            if (w_held) begin
                                n_state = sse_pkg::S_DEL_RD;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            sse_pkg::S_INS_RD: begin
                if (r_idx == r_pos) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_idx[sse_pkg::ADDR_W-1:0];
                    o_mem.wdata = r_key;
                    n_cnt       = r_cnt + sse_pkg::CNT_W'(1);
                    n_ok        = 1'b1;
                    n_state     = sse_pkg::S_DONE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = w_prev[sse_pkg::ADDR_W-1:0];
                    n_state     = sse_pkg::S_INS_WR;
                end
            end
            sse_pkg::S_INS_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[sse_pkg::ADDR_W-1:0];
                o_mem.wdata = i_rdata;
                n_idx       = w_prev;
                n_state     = sse_pkg::S_INS_RD;
            end
            sse_pkg::S_DEL_RD: begin
                if (w_next == r_cnt) begin
                    n_cnt   = r_cnt - sse_pkg::CNT_W'(1);
                    n_ok    = 1'b1;
                    n_state = sse_pkg::S_DONE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = w_next[sse_pkg::ADDR_W-1:0];
                    n_state     = sse_pkg::S_DEL_WR;
                end
            end
            sse_pkg::S_DEL_WR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx[sse_pkg::ADDR_W-1:0];
                o_mem.wdata = i_rdata;
                n_idx       = w_next;
                n_state     = sse_pkg::S_DEL_RD;
            end
            sse_pkg::S_DONE: begin
                n_state = sse_pkg::S_IDLE;
            end
            default: begin
                n_state = sse_pkg::S_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != sse_pkg::S_IDLE);
    assign o_valid        = (r_state == sse_pkg::S_DONE);
    assign o_res.success  = r_ok;
    assign o_res.full_res = r_full;
    assign o_key          = r_key;

endmodule

// ===== src/sorted_set_engine_core.sv =====
// Top level of the sorted set engine.
//
// The engine holds up to CAPACITY distinct signed 32-bit keys in ascending
// order and answers member test, insert and delete requests, one item at a
// time. An item is taken when start is high while busy is low; busy then
// stays high until the result has been shown. The result is present on o_res
// for exactly one cycle, marked by o_valid, and the receiver cannot stall it,
// so it must capture the result in that cycle. The work on an item is paced
// by the key store, with one read and one write port, and the one shared
// comparator: the search reads, then compares, each key examined, and ends
// in its read state, with no read, when it runs past the last key held; an
// insert or delete then reads and writes each entry moved and finishes in a
// read state that writes the new key or lowers the count; the result state
// and the return to idle, where the next item can be taken, follow. The
// worst case is an insert at the front of an almost full store. No clearing
// pass is needed after reset: the store is considered empty and entries
// beyond the key count are never read.
module sorted_set_engine_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  sse_pkg::t_req i_req,
    output logic          busy,
    output logic          o_valid,
    output sse_pkg::t_res o_res
);

    sse_pkg::t_mem_req w_mem;
    sse_pkg::t_key     w_rdata;
    sse_pkg::t_key     w_key;
    sse_pkg::t_cmp     w_cmp;

    // Sequencer: owns the key count and walks the store.
    sse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res),
        .o_mem   (w_mem),
        .i_rdata (w_rdata),
        .i_cmp   (w_cmp),
        .o_key   (w_key)
    );

    // Key store, read data registered.
    sse_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    // The one comparator, used on every search step.
    sse_cmp u_cmp (
        .i_data (w_rdata),
        .i_key  (w_key),
        .o_cmp  (w_cmp)
    );

endmodule

// ===== src/sse_chk.sv =====
// Port-level assertion checker for the sorted set engine, with its bind.
module sse_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input sse_pkg::t_req i_req,
    input logic          busy,
    input logic          o_valid,
    input sse_pkg::t_res o_res
);

    // A result only follows work in progress.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without an item in progress");

    // A result lasts one cycle and the engine is then free again.
    a_valid_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!o_valid && !busy))
        else $error("result not followed by idle");

    // An accepted item makes the engine busy.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but engine not busy");

    // A refused insert never also reports success.
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_res.success && o_res.full_res))
        else $error("success and full reported together");

endmodule

bind sorted_set_engine_core sse_chk u_sse_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

// ===== dv/sse_answer_checker.sv =====
// Checker for the sorted set engine: tracks the key set, predicts each answer and compares it.
module sse_answer_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  sse_pkg::t_req i_req,
    input  logic          o_valid,
    input  sse_pkg::t_res o_res,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        sse_pkg::t_req req;
        sse_pkg::t_res res;
    } t_answer;

    // Keys currently held, kept in ascending order.
    sse_pkg::t_key held_keys[$];
    t_answer       awaited_answers[$];

    function automatic sse_pkg::t_res apply_request(sse_pkg::t_req req);
        sse_pkg::t_res res;
        sse_pkg::t_key key;
        int            pos;
        logic          held;
        res = '0;
        key = $signed(req.value);
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < key)
            pos++;
        held = (pos < held_keys.size()) && (held_keys[pos] == key);
        case (req.op)
            sse_pkg::OP_MEMBER: begin
                res.success = held;
            end
            sse_pkg::OP_INSERT: begin
                if (!held) begin
                    if (held_keys.size() >= sse_pkg::CAPACITY) begin
                        res.full_res = 1'b1;
                    end else begin
                        held_keys.insert(pos, key);
                        res.success = 1'b1;
                    end
                end
            end
            sse_pkg::OP_DELETE: begin
                if (held) begin
                    held_keys.delete(pos);
                    res.success = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic check_answer(sse_pkg::t_res got);
        t_answer want;
        if (awaited_answers.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: answer success=%0b full=%0b with no request outstanding",
                         $realtime, got.success, got.full_res);
        end else begin
            want = awaited_answers.pop_front();
            if (got.success !== want.res.success || got.full_res !== want.res.full_res) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%0t: op %0d key %0d: expected success=%0b full=%0b, got %0b %0b",
                             $realtime, want.req.op, $signed(want.req.value),
                             want.res.success, want.res.full_res, got.success, got.full_res);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_keys.delete();
            awaited_answers.delete();
            o_pending <= 0;
        end else begin
            if (o_valid)
                check_answer(o_res);
            if (start && !busy)
                awaited_answers.push_back('{req: i_req, res: apply_request(i_req)});
            o_pending <= awaited_answers.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the sorted set engine testbench: clock, reset, request stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // The package names only the three real operations; code 3 is unused and
    // must leave the set alone.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int   POOL_SIZE      = 48;
    localparam int   FILL_COUNT     = 272;
    localparam int   WATCHDOG_LIMIT = 20000;
    // The slowest item, an insert at the front of a nearly full store, is
    // covered comfortably by the tail wait.
    localparam int   TAIL_CYCLES    = 4 * sse_pkg::CAPACITY + 100;
    localparam sse_pkg::t_key KEY_MIN = sse_pkg::t_key'(32'h8000_0000);
    localparam sse_pkg::t_key KEY_MAX = sse_pkg::t_key'(32'h7FFF_FFFF);

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    sse_pkg::t_req i_req   = '0;
    logic          busy;
    logic          o_valid;
    sse_pkg::t_res o_res;

    int     fail_count;
    int     pending;
    int     idle_pct     = 0;
    int     quiet_cycles = 0;

    // A small pool of keys so that member tests and deletes often hit keys
    // that are really held; fully random keys are mixed in as well.
    sse_pkg::t_key key_pool[POOL_SIZE];
    sse_pkg::t_key fill_keys[FILL_COUNT];

    always #5 i_clk = ~i_clk;

    sorted_set_engine_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    sse_answer_checker answers (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_valid      (o_valid),
        .o_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Watchdog: any cycle in which an item is taken or an answer is shown
    // counts as progress. A long enough stretch without either means the
    // engine has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one item and returns at the rising edge that takes it. Before
    // the item goes out the sender may idle for some cycles, which lets gaps
    // fall on any stage of the engine's work on the item before. Once start
    // is raised it stays up, with the item unchanged, until busy is seen low
    // at a rising edge.
    task automatic send_item(input logic [1:0] op, input sse_pkg::t_key key);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_req <= {op, key};
        start <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    function automatic sse_pkg::t_key pick_key();
        if ($urandom_range(99) < 70)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return sse_pkg::t_key'($urandom);
    endfunction

    // Mostly inserts and deletes on the pool, so that the set keeps changing
    // shape, with member tests and the odd unused operation code.
    task automatic random_items(input int count);
        int         roll;
        logic [1:0] op;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 40)
                op = sse_pkg::OP_INSERT;
            else if (roll < 70)
                op = sse_pkg::OP_DELETE;
            else if (roll < 95)
                op = sse_pkg::OP_MEMBER;
            else
                op = OP_SPARE;
            send_item(op, pick_key());
        end
    endtask

    initial begin
        int            j;
        sse_pkg::t_key swap;

        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = sse_pkg::t_key'($urandom);
        for (int i = 0; i < FILL_COUNT; i++)
            fill_keys[i] = sse_pkg::t_key'($urandom);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 20;

        // Directed opening: the empty store, both ends of the key range, a
        // duplicate insert, hits and misses, removal at front, middle and
        // back, a delete on an empty store and the unused operation code.
        send_item(sse_pkg::OP_MEMBER, KEY_MIN);
        send_item(sse_pkg::OP_INSERT, '0);
        send_item(sse_pkg::OP_INSERT, KEY_MAX);
        send_item(sse_pkg::OP_INSERT, KEY_MIN);
        send_item(sse_pkg::OP_INSERT, -1);
        send_item(sse_pkg::OP_INSERT, 1);
        send_item(sse_pkg::OP_INSERT, '0);
        send_item(sse_pkg::OP_MEMBER, KEY_MIN);
        send_item(sse_pkg::OP_MEMBER, KEY_MAX);
        send_item(sse_pkg::OP_MEMBER, 2);
        send_item(sse_pkg::OP_DELETE, '0);
        send_item(sse_pkg::OP_DELETE, '0);
        send_item(OP_SPARE, KEY_MAX);
        send_item(sse_pkg::OP_MEMBER, KEY_MAX);
        send_item(OP_SPARE, sse_pkg::t_key'(32'h5555_5555));
        send_item(sse_pkg::OP_DELETE, KEY_MIN);
        send_item(sse_pkg::OP_DELETE, KEY_MAX);
        send_item(sse_pkg::OP_DELETE, -1);
        send_item(sse_pkg::OP_DELETE, 1);
        send_item(sse_pkg::OP_DELETE, sse_pkg::t_key'(32'h5555_5555));
        send_item(sse_pkg::OP_MEMBER, sse_pkg::t_key'(32'hAAAA_AAAA));
        send_item(sse_pkg::OP_INSERT, sse_pkg::t_key'(32'hAAAA_AAAA));
        send_item(OP_SPARE, sse_pkg::t_key'(32'hAAAA_AAAA));

        random_items(300);

        idle_pct = 51;
        random_items(300);

        idle_pct = 0;

        // Fill the store past its capacity so that the later inserts are
        // refused, then probe the full store.
        for (int i = 0; i < FILL_COUNT; i++)
            send_item(sse_pkg::OP_INSERT, fill_keys[i]);
        send_item(sse_pkg::OP_INSERT, fill_keys[0]);
        send_item(sse_pkg::OP_INSERT, sse_pkg::t_key'($urandom));
        send_item(sse_pkg::OP_MEMBER, fill_keys[5]);
        send_item(sse_pkg::OP_DELETE, sse_pkg::t_key'($urandom));
        send_item(OP_SPARE, fill_keys[7]);
        send_item(sse_pkg::OP_DELETE, fill_keys[0]);
        send_item(sse_pkg::OP_INSERT, fill_keys[0]);
        send_item(sse_pkg::OP_INSERT, KEY_MIN);

        // Drain it again in a shuffled order.
        for (int i = FILL_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(i);
            swap = fill_keys[i];
            fill_keys[i] = fill_keys[j];
            fill_keys[j] = swap;
        end
        for (int i = 0; i < FILL_COUNT; i++)
            send_item(sse_pkg::OP_DELETE, fill_keys[i]);

        random_items(50);

        @(negedge i_clk);
        start <= 1'b0;

        while (pending != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
